>>> rtl/core/matrix4_vector_transform_core_macros.svh
// Assertion macros for the matrix-vector transform core.
// Used by the port checker; no other dependencies.
`ifndef MATRIX4_VECTOR_TRANSFORM_CORE_MACROS_SVH
`define MATRIX4_VECTOR_TRANSFORM_CORE_MACROS_SVH

// antecedent in this cycle implies consequent in the next
`define MVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("mvt check failed");

// antecedent implies consequent in the same cycle
`define MVT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("mvt check failed");

`endif

>>> rtl/core/mvt_pkg.sv
// Shared types and constants for the matrix-vector transform core.
// No dependencies.
package mvt_pkg;

	localparam int DIM        = 4;
	localparam int FIELD_W    = 32;
	localparam int IDX_W      = 4;
	localparam int S_TDATA_W  = 168;   // 4 + 5*32 = 164, padded to bytes
	localparam int M_TDATA_W  = 128;

	typedef enum logic [1:0] {
		OP_WR_HELD = 2'd0,
		OP_WR_OPER = 2'd1,
		OP_VEC4    = 2'd2,
		OP_POINT   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RUN,
		S_DRAIN,
		S_PUSH,
		S_COMMIT
	} state_t;

	typedef struct packed {
		logic       wr_held;
		logic       wr_oper;
		logic       latch_vec;
		logic       point;      // latched with the vector
		logic       step_valid;
		logic       step_first;
		logic       step_last;
		logic       step_point; // use held element unscaled
		logic       step_matmul;
		logic [1:0] step_k;
		logic [1:0] step_col;
		logic       load_out;
		logic       commit;
	} cmd_t;

endpackage

>>> rtl/core/mvt_ctrl.sv
// Sequencer for the transform core: handshakes and step issue.
// Depends on mvt_pkg.
module mvt_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [1:0]                operation,
	input  logic [mvt_pkg::IDX_W-1:0] element_index,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output mvt_pkg::cmd_t             cmd
);
	import mvt_pkg::*;

	state_t     state_q, state_d;
	logic [3:0] step_q, step_d;
	logic       matmul_q, matmul_d;
	logic       point_q, point_d;
	logic       mvalid_q;
	logic       accept;
	logic       run_end;

	assign accept   = s_tvalid && s_tready;
	assign run_end  = matmul_q ? (step_q == 4'd15) : (step_q[1:0] == 2'd3);
	assign m_tvalid = mvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			step_q   <= '0;
			matmul_q <= 1'b0;
			point_q  <= 1'b0;
			mvalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			step_q   <= step_d;
			matmul_q <= matmul_d;
			point_q  <= point_d;
			if (cmd.load_out)
				mvalid_q <= 1'b1;
			else if (m_tready)
				mvalid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		matmul_d = matmul_q;
		point_d  = point_q;
		s_tready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (accept) begin
					step_d = '0;
					unique case (op_t'(operation))
						OP_WR_HELD: cmd.wr_held = 1'b1;
						OP_WR_OPER: begin
							cmd.wr_oper = 1'b1;
							if (element_index == 4'd15) begin
								matmul_d = 1'b1;
								state_d  = S_RUN;
							end
						end
						OP_VEC4, OP_POINT: begin
							cmd.latch_vec = 1'b1;
							cmd.point     = (op_t'(operation) == OP_POINT);
							point_d       = (op_t'(operation) == OP_POINT);
							matmul_d      = 1'b0;
							state_d       = S_RUN;
						end
					endcase
				end
			end
			S_RUN: begin
				cmd.step_valid  = 1'b1;
				cmd.step_k      = step_q[1:0];
				cmd.step_col    = matmul_q ? step_q[3:2] : 2'd0;
				cmd.step_first  = (step_q[1:0] == 2'd0);
				cmd.step_last   = (step_q[1:0] == 2'd3);
				cmd.step_matmul = matmul_q;
				cmd.step_point  = point_q && !matmul_q && (step_q[1:0] == 2'd3);
				step_d          = step_q + 4'd1;
				if (run_end)
					state_d = S_DRAIN;
			end
			S_DRAIN: state_d = matmul_q ? S_COMMIT : S_PUSH;
			S_PUSH: begin
				if (!mvalid_q || m_tready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

>>> rtl/core/mvt_datapath.sv
// Four multiply-accumulate lanes, one per matrix row, with held and operand stores.
// Depends on mvt_pkg.
module mvt_datapath #(
	parameter int FRAC_BITS  = 16,
	parameter int ELEM_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mvt_pkg::cmd_t                   cmd,
	input  logic [mvt_pkg::IDX_W-1:0]       element_index,
	input  logic signed [ELEM_WIDTH-1:0]    element_value,
	input  logic signed [ELEM_WIDTH-1:0]    vec_in [mvt_pkg::DIM],
	output logic [mvt_pkg::M_TDATA_W-1:0]   out_data
);
	import mvt_pkg::*;

	localparam int PROD_W = 2 * ELEM_WIDTH;
	localparam int ACC_W  = PROD_W - FRAC_BITS + 2;

	logic signed [ELEM_WIDTH-1:0] held_q   [DIM][DIM];  // [row][col]
	logic signed [ELEM_WIDTH-1:0] temp_q   [DIM][DIM];
	logic signed [ELEM_WIDTH-1:0] oper_q   [DIM*DIM];
	logic signed [ELEM_WIDTH-1:0] vec_q    [DIM];
	logic                         point_q;
	logic signed [ACC_W-1:0]      acc_q    [DIM];
	logic signed [ACC_W-1:0]      term_s1  [DIM];
	logic                         valid_s1, first_s1, last_s1;
	logic [1:0]                   col_s1;
	logic [M_TDATA_W-1:0]         out_q;

	logic signed [ELEM_WIDTH-1:0] b_sel;
	logic signed [ACC_W-1:0]      term_d   [DIM];
	logic signed [ACC_W-1:0]      sum      [DIM];
	logic signed [ELEM_WIDTH-1:0] sat_val  [DIM];

	always_comb begin
		logic signed [PROD_W-1:0] prod;
		logic signed [PROD_W-1:0] shifted;
		logic [ACC_W-ELEM_WIDTH:0] upper;
		b_sel = cmd.step_matmul ? oper_q[{cmd.step_col, cmd.step_k}] : vec_q[cmd.step_k];
		for (int r = 0; r < DIM; r++) begin
			prod    = held_q[r][cmd.step_k] * b_sel;
			shifted = prod >>> FRAC_BITS;   // floor
			term_d[r] = cmd.step_point ? ACC_W'(held_q[r][cmd.step_k])
			                           : ACC_W'(shifted);
			sum[r]  = (first_s1 ? ACC_W'(0) : acc_q[r]) + term_s1[r];
			upper   = sum[r][ACC_W-1:ELEM_WIDTH-1];
			if ((&upper) || !(|upper))
				sat_val[r] = sum[r][ELEM_WIDTH-1:0];
			else if (sum[r][ACC_W-1])
				sat_val[r] = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
			else
				sat_val[r] = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			for (int r = 0; r < DIM; r++)
				for (int c = 0; c < DIM; c++)
					held_q[r][c] <= '0;
		end else begin
			valid_s1 <= cmd.step_valid;
			if (cmd.wr_held)
				held_q[element_index[1:0]][element_index[3:2]] <= element_value;
			else if (cmd.commit)
				held_q <= temp_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_oper)
			oper_q[element_index] <= element_value;
		if (cmd.latch_vec) begin
			vec_q   <= vec_in;
			point_q <= cmd.point;
		end
		first_s1 <= cmd.step_first;
		last_s1  <= cmd.step_last;
		col_s1   <= cmd.step_col;
		term_s1  <= term_d;
		if (valid_s1) begin
			for (int r = 0; r < DIM; r++) begin
				acc_q[r] <= sum[r];
				if (last_s1)
					temp_q[r][col_s1] <= sat_val[r];
			end
		end
		if (cmd.load_out) begin
			for (int r = 0; r < DIM; r++)
				out_q[r*FIELD_W +: FIELD_W] <= (point_q && r == DIM - 1) ? '0
					: FIELD_W'(temp_q[r][0]);
		end
	end

	assign out_data = out_q;

endmodule

>>> rtl/core/matrix4_vector_transform_core.sv
// Channel  | dir | tdata (low bit up)                               | tuser
// s_axis   | in  | element_index, element_value, vec_x..vec_w, pad | operation
// m_axis   | out | out_x, out_y, out_z, out_w                       | -
// A vector or point passes through 4 lane steps (one matrix column per step),
// one drain step and one load of the output register before its result shows.
// No new item is accepted until that load is done.
// A write of operand element 15 multiplies the matrices in 16 lane steps plus
// drain and commit. Other element writes leave the core idle and ready.
// Reset clears the held matrix and control; the operand store is not reset.
// A result waiting on m_tready holds the next vector in its load step.
// Top level: mvt_ctrl sequencer and mvt_datapath lanes; depends on mvt_pkg.
module matrix4_vector_transform_core #(
	parameter int FRAC_BITS  = 16,
	parameter int ELEM_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// element_index[3:0], element_value, vec_x, vec_y, vec_z, vec_w, zero pad
	input  logic [mvt_pkg::S_TDATA_W-1:0] s_tdata,
	// operation
	input  logic [1:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// out_x, out_y, out_z, out_w
	output logic [mvt_pkg::M_TDATA_W-1:0] m_tdata
);
	import mvt_pkg::*;

	cmd_t                         cmd;
	logic [IDX_W-1:0]             element_index;
	logic signed [ELEM_WIDTH-1:0] element_value;
	logic signed [ELEM_WIDTH-1:0] vec_in [DIM];

	assign element_index = s_tdata[IDX_W-1:0];
	assign element_value = s_tdata[IDX_W +: ELEM_WIDTH];
	always_comb begin
		for (int c = 0; c < DIM; c++)
			vec_in[c] = s_tdata[IDX_W + (c + 1) * FIELD_W +: ELEM_WIDTH];
	end

	mvt_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.operation     (s_tuser),
		.element_index (element_index),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.cmd           (cmd)
	);

	mvt_datapath #(
		.FRAC_BITS  (FRAC_BITS),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.element_index (element_index),
		.element_value (element_value),
		.vec_in        (vec_in),
		.out_data      (m_tdata)
	);

endmodule

>>> rtl/core/mvt_checker.sv
// Port-level checks for the transform core, bound to the top level.
// Depends on mvt_pkg and matrix4_vector_transform_core_macros.svh.
`include "matrix4_vector_transform_core_macros.svh"

module mvt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [mvt_pkg::S_TDATA_W-1:0] s_tdata,
	input logic [1:0]                    s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [mvt_pkg::M_TDATA_W-1:0] m_tdata
);
	import mvt_pkg::*;

	logic acc_in, is_store, is_vec;

	assign acc_in   = s_tvalid && s_tready;
	assign is_store = (s_tuser == OP_WR_HELD)
		|| ((s_tuser == OP_WR_OPER) && (s_tdata[IDX_W-1:0] != 4'd15));
	assign is_vec   = (s_tuser == OP_VEC4) || (s_tuser == OP_POINT);

	`MVT_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`MVT_ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))
	`MVT_ASSERT_NEXT(a_store_fast, clk, arst_n, acc_in && is_store, s_tready)
	`MVT_ASSERT_NEXT(a_vec_busy, clk, arst_n, acc_in && is_vec, !s_tready && !$rose(m_tvalid))

endmodule

bind matrix4_vector_transform_core mvt_checker u_mvt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> tb/testbench.sv
// Self-checking testbench for matrix4_vector_transform_core.
// Predicts matrix writes, matrix products and vector transforms in Q16.16.
// Depends on mvt_pkg and the core RTL.
`timescale 1ns / 1ps

class transform_scoreboard;
	logic signed [31:0] held [16];
	logic signed [31:0] operand [16];
	logic [127:0] pending [$];
	int errors;
	int shown;

	function new();
		foreach (held[i]) held[i] = '0;
		foreach (operand[i]) operand[i] = '0;
		errors = 0;
		shown = 0;
	endfunction

	// product shifted right by 16, floor rounding (arithmetic shift)
	function longint qmul(logic signed [31:0] a, logic signed [31:0] b);
		longint p;
		p = longint'(a) * longint'(b);
		return p >>> 16;
	endfunction

	function logic [31:0] clamp(longint s);
		if (s > 64'sd2147483647) return 32'h7fffffff;
		if (s < -64'sd2147483648) return 32'h80000000;
		return s[31:0];
	endfunction

	function void note_item(mvt_pkg::op_t op, logic [3:0] idx, logic [31:0] val,
			logic [31:0] vx, logic [31:0] vy, logic [31:0] vz, logic [31:0] vw);
		logic signed [31:0] v [4];
		logic signed [31:0] prod [16];
		logic [127:0] res;
		longint s;
		v[0] = vx; v[1] = vy; v[2] = vz; v[3] = vw;
		case (op)
			mvt_pkg::OP_WR_HELD: held[idx] = val;
			mvt_pkg::OP_WR_OPER: begin
				operand[idx] = val;
				if (idx == 4'd15) begin
					for (int c = 0; c < 4; c++)
						for (int r = 0; r < 4; r++) begin
							s = 0;
							for (int e = 0; e < 4; e++)
								s += qmul(held[r + 4 * e], operand[e + 4 * c]);
							prod[r + 4 * c] = clamp(s);
						end
					held = prod;
				end
			end
			default: begin
				for (int r = 0; r < 4; r++) begin
					s = 0;
					for (int c = 0; c < 3; c++)
						s += qmul(held[r + 4 * c], v[c]);
					if (op == mvt_pkg::OP_POINT) s += longint'(held[r + 12]);
					else s += qmul(held[r + 12], v[3]);
					res[32 * r +: 32] = clamp(s);
				end
				if (op == mvt_pkg::OP_POINT) res[127:96] = '0;
				pending.push_back(res);
			end
		endcase
	endfunction

	function void check_result(logic [127:0] got);
		logic [127:0] exp_r;
		if (pending.size() == 0) begin
			errors++;
			if (shown++ < 10) $display("unexpected result %h", got);
			return;
		end
		exp_r = pending.pop_front();
		for (int f = 0; f < 4; f++)
			if (got[32 * f +: 32] !== exp_r[32 * f +: 32]) begin
				errors++;
				if (shown++ < 10)
					$display("field %0d: expected %h, got %h", f, exp_r[32 * f +: 32],
						got[32 * f +: 32]);
			end
	endfunction
endclass

module testbench;
	import mvt_pkg::*;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	longint cycles;
	int stall_mode;
	transform_scoreboard sb;

	matrix4_vector_transform_core DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 400000) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// receiver stalls: phases of always-ready, random, and long stalls
	initial begin
		m_tready = 1'b0;
		stall_mode = 0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 2) != 0);
				default: m_tready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);

	function logic [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(0, 32'h3ffff) - 32'h20000;
			3: return 32'h00010000;
			default: return $urandom;
		endcase
	endfunction

	int burst_left;

	task automatic send(op_t op, logic [3:0] idx, logic [31:0] val,
			logic [31:0] vx, logic [31:0] vy, logic [31:0] vz, logic [31:0] vw);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 20);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {4'd0, vw, vz, vy, vx, val, idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_item(op, idx, val, vx, vy, vz, vw);
		burst_left--;
	endtask

	task automatic send_matrix(bit to_operand, bit identity_ish);
		logic [31:0] val;
		for (int i = 0; i < 16; i++) begin
			if (identity_ish)
				val = (i % 5 == 0 ? 32'h00010000 : 32'h0) + $urandom_range(0, 255) - 128;
			else
				val = rand_value();
			send(to_operand ? OP_WR_OPER : OP_WR_HELD, i[3:0], val, $urandom, $urandom,
				$urandom, $urandom);
		end
	endtask

	initial begin
		int n;
		sb = new();
		burst_left = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_WR_HELD;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero matrix, extremes, saturation, product with a random operand
		send(OP_VEC4, 4'd0, 32'h0, 32'h7fffffff, 32'h80000000, 32'h1, 32'hffffffff);
		send(OP_POINT, 4'd15, 32'hffffffff, 32'h7fffffff, 32'h80000000, 32'h0, 32'h0);
		for (int i = 0; i < 16; i++)
			send(OP_WR_HELD, i[3:0], (i % 5 == 0) ? 32'h7fffffff : 32'h80000000,
				32'h0, 32'h0, 32'h0, 32'h0);
		send(OP_VEC4, 4'd0, 32'h0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		send(OP_VEC4, 4'd0, 32'h0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
		send(OP_POINT, 4'd0, 32'h0, 32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h12345678);
		send_matrix(1'b1, 1'b0);

		// random: mostly transforms, mixed with matrix loads, products and element writes
		n = 0;
		while (n < 1700) begin
			case ($urandom_range(0, 9))
				0: begin send_matrix(1'b0, $urandom_range(0, 1)); n += 16; end
				1: begin send_matrix(1'b1, $urandom_range(0, 1)); n += 16; end
				2: begin
					send($urandom_range(0, 1) ? OP_WR_HELD : OP_WR_OPER, 4'($urandom),
						rand_value(), $urandom, $urandom, $urandom, $urandom);
					n++;
				end
				default: begin
					send($urandom_range(0, 1) ? OP_VEC4 : OP_POINT, 4'($urandom), $urandom,
						rand_value(), rand_value(), rand_value(), rand_value());
					n++;
				end
			endcase
		end
		s_tvalid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
